@@ rtl/ite_pkg.sv @@
// Package for the ISO timestamp reader: shared types and constants.
// No dependencies.
package ite_pkg;

   localparam int CodeW = 16;
   localparam int MsW   = 49;

   // Job handed from the scanner to the arithmetic back end
   typedef struct packed {
      logic        ok;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        has_time;
      logic [13:0] hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
      logic [9:0]  frac_ms;
   } job_type;

   localparam logic [15:0] ChSpace = 16'h0020;
   localparam logic [15:0] ChTab   = 16'h0009;
   localparam logic [15:0] ChCr    = 16'h000D;
   localparam logic [15:0] ChLf    = 16'h000A;
   localparam logic [15:0] ChNbsp  = 16'h00A0;
   localparam logic [15:0] ChBom   = 16'hFEFF;
   localparam logic [15:0] ChDash  = 16'h002D;
   localparam logic [15:0] ChColon = 16'h003A;
   localparam logic [15:0] ChDot   = 16'h002E;
   localparam logic [15:0] ChComma = 16'h002C;
   localparam logic [15:0] ChT     = 16'h0054;

endpackage

@@ rtl/ite_front.sv @@
// Scanner: accepts code units, checks the grammar and collects the fields.
// Depends on ite_pkg.
module ite_front import ite_pkg::*; #(
   parameter int MAX_TEXT_LENGTH  = 32,
   parameter int MAX_CLOCK_LENGTH = 20,
   parameter int MAX_FIELD_DIGITS = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [CodeW-1:0] in_code,
   input  logic             in_last,
   output logic             job_valid,
   input  logic             job_ready,
   output job_type          job
);

   logic        started_ff, started_in;
   logic [5:0]  body_ff, body_in;
   logic [5:0]  pend_ff, pend_in;
   logic        pbad_ff, pbad_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic        cst_ff, cst_in;
   logic [5:0]  clen_ff, clen_in;
   logic [1:0]  fcnt_ff, fcnt_in;
   logic [29:0] fval_ff, fval_in;
   logic [3:0]  fdig_ff, fdig_in;
   logic [29:0] first_ff, first_in;
   logic [29:0] second_ff, second_in;
   logic        infr_ff, infr_in;
   logic [2:0]  frd_ff, frd_in;
   logic [9:0]  frms_ff, frms_in;
   logic        failed_ff, failed_in;

   logic        take;
   logic        blank, digit;
   logic [3:0]  dv;
   logic [6:0]  pos;
   logic [5:0]  p;
   job_type     job_in;
   logic [29:0] hh, mm;

   assign in_ready = ~job_valid | job_ready;
   assign take     = in_valid & in_ready;
   assign blank = in_code == ChSpace || in_code == ChTab || in_code == ChCr ||
                  in_code == ChLf || in_code == ChNbsp || in_code == ChBom;
   assign digit = in_code >= 16'h0030 && in_code <= 16'h0039;
   assign dv    = in_code[3:0];

   // per-unit state update
   always_comb begin
      started_in = started_ff; body_in = body_ff; pend_in = pend_ff;
      pbad_in = pbad_ff; year_in = year_ff; month_in = month_ff; day_in = day_ff;
      cst_in = cst_ff; clen_in = clen_ff; fcnt_in = fcnt_ff; fval_in = fval_ff;
      fdig_in = fdig_ff; first_in = first_ff; second_in = second_ff;
      infr_in = infr_ff; frd_in = frd_ff; frms_in = frms_ff; failed_in = failed_ff;
      pos = 7'(body_ff) + 7'(pend_ff);
      p = body_ff;
      if (!failed_ff) begin
         if (blank) begin
            if (started_ff) begin
               if (pos < 7'd10 || (pos == 7'd10 && in_code != ChSpace) || cst_ff)
                  pbad_in = 1'b1;
               if (pend_ff != 6'd63) pend_in = pend_ff + 6'd1;
            end
         end else begin
            started_in = 1'b1;
            if (pend_ff != 6'd0 && (pbad_ff || pos + 7'd1 > 7'(MAX_TEXT_LENGTH)))
               failed_in = 1'b1;
            else if (pos + 7'd1 > 7'(MAX_TEXT_LENGTH))
               failed_in = 1'b1;
            else begin
               p = pos[5:0];
               pend_in = 6'd0;
               body_in = pos[5:0] + 6'd1;
               if (p < 6'd10) begin
                  if (p == 6'd4 || p == 6'd7) begin
                     if (in_code != ChDash) failed_in = 1'b1;
                  end else if (!digit) failed_in = 1'b1;
                  else if (p < 6'd4) year_in = 14'(year_ff * 14'd10) + 14'(dv);
                  else if (p < 6'd7) month_in = 7'(month_ff * 7'd10) + 7'(dv);
                  else day_in = 7'(day_ff * 7'd10) + 7'(dv);
               end else if (p == 6'd10) begin
                  if (in_code != ChT && in_code != ChSpace) failed_in = 1'b1;
               end else begin
                  cst_in  = 1'b1;
                  clen_in = clen_ff + 6'd1;
                  if (clen_in > 6'(MAX_CLOCK_LENGTH)) failed_in = 1'b1;
                  else if (in_code == ChColon) begin
                     if (infr_ff || fdig_ff == 4'd0 || fcnt_ff >= 2'd2) failed_in = 1'b1;
                     else begin
                        if (fcnt_ff == 2'd0) first_in = fval_ff;
                        else second_in = fval_ff;
                        fcnt_in = fcnt_ff + 2'd1;
                        fval_in = '0;
                        fdig_in = '0;
                     end
                  end else if (in_code == ChDot || in_code == ChComma) begin
                     if (infr_ff) failed_in = 1'b1;
                     else infr_in = 1'b1;
                  end else if (digit) begin
                     if (infr_ff) begin
                        frd_in = frd_ff + 3'd1;
                        if (frd_ff >= 3'd6) failed_in = 1'b1;
                        else if (frd_ff < 3'd3) frms_in = 10'(frms_ff * 10'd10) + 10'(dv);
                     end else begin
                        fdig_in = fdig_ff + 4'd1;
                        if (fdig_in > 4'(MAX_FIELD_DIGITS)) failed_in = 1'b1;
                        else fval_in = 30'(fval_ff * 30'd10) + 30'(dv);
                     end
                  end else failed_in = 1'b1;
               end
            end
         end
      end
   end

   // final checks on the collected fields
   always_comb begin
      hh = (fcnt_in == 2'd2) ? first_in : '0;
      mm = (fcnt_in == 2'd2) ? second_in : first_in;
      job_in.year     = year_in;
      job_in.month    = month_in[3:0];
      job_in.day      = day_in[4:0];
      job_in.has_time = body_in > 6'd10;
      job_in.hours    = hh[13:0];
      job_in.minutes  = mm[5:0];
      job_in.seconds  = fval_in[5:0];
      case (frd_in)
         3'd0:    job_in.frac_ms = 10'd0;
         3'd1:    job_in.frac_ms = 10'(frms_in * 10'd100);
         3'd2:    job_in.frac_ms = 10'(frms_in * 10'd10);
         default: job_in.frac_ms = frms_in;
      endcase
      job_in.ok = started_in && !failed_in && body_in >= 6'd10 &&
                  month_in >= 7'd1 && month_in <= 7'd12 &&
                  day_in >= 7'd1 && day_in <= 7'd31 &&
                  year_in >= 14'd1601 && year_in <= 14'd9999;
      if (body_in > 6'd10) begin
         if (!cst_in || clen_in < 6'd4 || clen_in > 6'(MAX_CLOCK_LENGTH) ||
             fdig_in == 4'd0 || fcnt_in == 2'd0 || (infr_in && frd_in == 3'd0) ||
             hh > 30'd9999 || mm > 30'd59 || fval_in > 30'd59)
            job_in.ok = 1'b0;
      end
   end

   // state registers; everything clears after the last unit
   always_ff @(posedge clock) begin
      if (reset || (take && in_last)) begin
         started_ff <= 1'b0; body_ff <= '0; pend_ff <= '0; pbad_ff <= 1'b0;
         year_ff <= '0; month_ff <= '0; day_ff <= '0; cst_ff <= 1'b0;
         clen_ff <= '0; fcnt_ff <= '0; fval_ff <= '0; fdig_ff <= '0;
         first_ff <= '0; second_ff <= '0; infr_ff <= 1'b0; frd_ff <= '0;
         frms_ff <= '0; failed_ff <= 1'b0;
      end else if (take) begin
         started_ff <= started_in; body_ff <= body_in; pend_ff <= pend_in;
         pbad_ff <= pbad_in; year_ff <= year_in; month_ff <= month_in;
         day_ff <= day_in; cst_ff <= cst_in; clen_ff <= clen_in;
         fcnt_ff <= fcnt_in; fval_ff <= fval_in; fdig_ff <= fdig_in;
         first_ff <= first_in; second_ff <= second_in; infr_ff <= infr_in;
         frd_ff <= frd_in; frms_ff <= frms_in; failed_ff <= failed_in;
      end
   end

   // one-entry queue to the back end
   always_ff @(posedge clock) begin
      if (reset) job_valid <= 1'b0;
      else if (take && in_last) job_valid <= 1'b1;
      else if (job_ready) job_valid <= 1'b0;
      if (take && in_last) job <= job_in;
   end

endmodule

@@ rtl/ite_back.sv @@
// Arithmetic back end: days from civil date and ms total, one job at a time.
// Depends on ite_pkg.
module ite_back import ite_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           job_valid,
   output logic           job_ready,
   input  job_type        job,
   output logic           out_valid,
   input  logic           out_ready,
   output logic           out_ok,
   output logic [MsW-1:0] out_ms
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_DAYS = 4'b0010, S_SUM = 4'b0100, S_OUT = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   job_type     job_ff;
   logic [13:0] y;
   logic [13:0] yy;
   logic [3:0]  mp;
   logic [8:0]  mstart;
   logic [8:0]  doy;
   logic [26:0] cprod;
   logic [7:0]  cent;
   logic [21:0] days_ff;
   logic [47:0] tms_ff;
   logic        ok_ff;
   logic [MsW-1:0] ms_ff;

   assign job_ready = state_ff == S_IDLE;
   assign out_valid = state_ff == S_OUT;
   assign out_ok    = ok_ff;
   assign out_ms    = ms_ff;

   // year shifted so the year starts in March; 1600 base keeps it positive
   always_comb begin
      y   = (job_ff.month <= 4'd2) ? job_ff.year - 14'd1 : job_ff.year;
      mp  = (job_ff.month > 4'd2) ? job_ff.month - 4'd3 : job_ff.month + 4'd9;
      // first day of each month counted from March
      case (mp)
         4'd0:    mstart = 9'd0;
         4'd1:    mstart = 9'd31;
         4'd2:    mstart = 9'd61;
         4'd3:    mstart = 9'd92;
         4'd4:    mstart = 9'd122;
         4'd5:    mstart = 9'd153;
         4'd6:    mstart = 9'd184;
         4'd7:    mstart = 9'd214;
         4'd8:    mstart = 9'd245;
         4'd9:    mstart = 9'd275;
         4'd10:   mstart = 9'd306;
         4'd11:   mstart = 9'd337;
         default: mstart = 9'd0;
      endcase
      doy = mstart + 9'(job_ff.day) - 9'd1;
      yy  = y - 14'd1600;
      // centuries by reciprocal multiplication, exact for the legal year range
      cprod = 27'(yy) * 27'd5243;
      cent  = cprod[26:19];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (job_valid) state_in = S_DAYS;
         S_DAYS:  state_in = S_SUM;
         S_SUM:   state_in = S_OUT;
         S_OUT:   if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      if (state_ff == S_IDLE) job_ff <= job;
      if (state_ff == S_DAYS) begin
         // days since 1600-03-01; leap corrections over the full offset
         days_ff <= 22'(32'(yy) * 32'd365 + 32'(yy[13:2]) - 32'(cent)
                    + 32'(cent[7:2]) + 32'(doy));
         tms_ff <= 48'(job_ff.hours) * 48'd3600000 + 48'(job_ff.minutes) * 48'd60000
                   + 48'(job_ff.seconds) * 48'd1000 + 48'(job_ff.frac_ms);
      end
      if (state_ff == S_SUM) begin
         ok_ff <= job_ff.ok;
         ms_ff <= job_ff.ok ?
            MsW'(($signed({1'b0, days_ff}) - 23'sd135080) * 49'sd86400000
                 + (job_ff.has_time ? $signed({1'b0, tms_ff}) : 49'sd0)) : '0;
      end
   end

endmodule

@@ rtl/iso_timestamp_to_epoch_ms.sv @@
// ISO 8601 timestamp reader, top level. Takes one UTF-16 code unit per cycle
// and returns one result on the unit marked last. Depends on ite_pkg.
//
// Units are taken at one per cycle. After the last unit a result is offered
// by the back end's date and millisecond pipeline, and the back end takes a
// new text only once the previous result has been taken; the next text may
// stream in meanwhile and waits only if the one-entry queue is full.
module iso_timestamp_to_epoch_ms import ite_pkg::*; #(
   parameter int MAX_TEXT_LENGTH  = 32,
   parameter int MAX_CLOCK_LENGTH = 20,
   parameter int MAX_FIELD_DIGITS = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // code[15:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // epoch_ms[48:0], zero fill
   output logic        rsp_tuser    // valid_res
);

   logic           job_valid, job_ready;
   job_type        job;
   logic [MsW-1:0] ms;

   ite_front #(
      .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH), .MAX_CLOCK_LENGTH(MAX_CLOCK_LENGTH),
      .MAX_FIELD_DIGITS(MAX_FIELD_DIGITS)
   ) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_code(req_tdata), .in_last(req_tlast),
      .job_valid, .job_ready, .job
   );

   ite_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_ok(rsp_tuser), .out_ms(ms)
   );

   assign rsp_tdata = {7'd0, ms};

endmodule

@@ rtl/ite_checker.sv @@
// Port-level checker for the timestamp reader, bound to the top level.
// Depends on the top level's ports only.
module ite_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 56'd0)
      else $error("invalid result not zero");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:49] == 7'd0)
      else $error("padding bits set");
endmodule

bind iso_timestamp_to_epoch_ms ite_checker u_chk (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);
